[hdl/mm3_pkg.sv]
`timescale 1ns / 1ps

package mm3_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 3;
	localparam int unsigned TdataW = 40;

	localparam logic [WordW-1:0] C1_MUL  = 32'hcc9e2d51;
	localparam logic [WordW-1:0] C2_MUL  = 32'h1b873593;
	localparam logic [WordW-1:0] MIX_ADD = 32'he6546b64;
	localparam logic [WordW-1:0] FM_MUL1 = 32'h85ebca6b;
	localparam logic [WordW-1:0] FM_MUL2 = 32'hc2b2ae35;

	localparam logic [CountW-1:0] FULL_COUNT = 3'd4;

	// Datapath operations issued by the controller
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_LOAD = 4'd1;
	localparam op_t OP_MUL1 = 4'd2;
	localparam op_t OP_MUL2 = 4'd3;
	localparam op_t OP_MIX  = 4'd4;
	localparam op_t OP_TAIL = 4'd5;
	localparam op_t OP_LEN  = 4'd6;
	localparam op_t OP_FM1  = 4'd7;
	localparam op_t OP_FM2  = 4'd8;
	localparam op_t OP_EMIT = 4'd9;

	typedef struct packed {
		op_t  op;
		logic key_start;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fin;
		logic out_busy;
	} status_t;

	function automatic logic [WordW-1:0] rotl15(input logic [WordW-1:0] x);
		rotl15 = {x[WordW-16:0], x[WordW-1:WordW-15]};
	endfunction

	function automatic logic [WordW-1:0] rotl13(input logic [WordW-1:0] x);
		rotl13 = {x[WordW-14:0], x[WordW-1:WordW-13]};
	endfunction

	// Keep only the valid low bytes of a partial word
	function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] cnt);
		case (cnt)
			3'd0: tail_mask = 32'h0000_0000;
			3'd1: tail_mask = 32'h0000_00ff;
			3'd2: tail_mask = 32'h0000_ffff;
			3'd3: tail_mask = 32'h00ff_ffff;
			default: tail_mask = 32'hffff_ffff;
		endcase
	endfunction

endpackage

[hdl/mm3_ctrl.sv]
`timescale 1ns / 1ps

module mm3_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mm3_pkg::status_t st,
	output mm3_pkg::cmd_t    cmd
);
	import mm3_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_MIX  = 3'd3;
	localparam logic [2:0] S_LEN  = 3'd4;
	localparam logic [2:0] S_FM1  = 3'd5;
	localparam logic [2:0] S_FM2  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic       in_key_q, in_key_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_key_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			in_key_q <= in_key_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_key_d      = in_key_q;
		cmd.op        = OP_NONE;
		cmd.key_start = 1'b0;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op        = OP_LOAD;
					cmd.key_start = !in_key_q;
					in_key_d      = 1'b1;
					state_d       = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				state_d = S_MIX;
			end
			S_MIX: begin
				cmd.op = st.full ? OP_MIX : OP_TAIL;
				if (!st.fin) begin
					state_d = S_IDLE;
				end else begin
					in_key_d = 1'b0;
					state_d  = st.full ? S_LEN : S_FM1;
				end
			end
			S_LEN: begin
				cmd.op  = OP_LEN;
				state_d = S_FM1;
			end
			S_FM1: begin
				cmd.op  = OP_FM1;
				state_d = S_FM2;
			end
			S_FM2: begin
				cmd.op  = OP_FM2;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the hash
				if (!st.out_busy) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/mm3_datapath.sv]
`timescale 1ns / 1ps

module mm3_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         seed_we,
	input  logic [mm3_pkg::WordW-1:0]    seed_wdata,
	input  logic [mm3_pkg::WordW-1:0]    key_word,
	input  logic [mm3_pkg::CountW-1:0]   byte_count,
	input  logic                         last,
	input  mm3_pkg::cmd_t                cmd,
	output mm3_pkg::status_t             st,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mm3_pkg::WordW-1:0]    hash
);
	import mm3_pkg::*;

	logic [WordW-1:0]  seed_q;
	logic [WordW-1:0]  w_q;
	logic [WordW-1:0]  h_q;
	logic [WordW-1:0]  len_q;
	logic [WordW-1:0]  out_q;
	logic              out_valid_q;
	logic              full_q;
	logic              fin_q;
	logic [CountW-1:0] cnt;
	logic [WordW-1:0]  mixed;
	logic [WordW-1:0]  fm_in;

	// clamp counts above four
	assign cnt   = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
	assign mixed = rotl13(h_q ^ w_q);
	assign fm_in = h_q ^ {13'd0, h_q[WordW-1:13]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				w_q    <= key_word & tail_mask(cnt);
				full_q <= (cnt == FULL_COUNT);
				fin_q  <= (cnt != FULL_COUNT) || last;
				if (cmd.key_start) begin
					h_q   <= seed_q;
					len_q <= {{(WordW-CountW){1'b0}}, cnt};
				end else begin
					len_q <= len_q + {{(WordW-CountW){1'b0}}, cnt};
				end
			end
			OP_MUL1: w_q <= w_q * C1_MUL;
			OP_MUL2: w_q <= rotl15(w_q) * C2_MUL;
			OP_MIX:  h_q <= mixed + {mixed[WordW-3:0], 2'b00} + MIX_ADD;
			OP_TAIL: h_q <= h_q ^ w_q ^ len_q;
			OP_LEN:  h_q <= h_q ^ len_q;
			OP_FM1:  h_q <= (h_q ^ {16'd0, h_q[WordW-1:16]}) * FM_MUL1;
			OP_FM2:  h_q <= fm_in * FM_MUL2;
			OP_EMIT: out_q <= h_q ^ {16'd0, h_q[WordW-1:16]};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.full     = full_q;
	assign st.fin      = fin_q;
	assign st.out_busy = out_valid_q && !out_ready;
	assign out_valid   = out_valid_q;
	assign hash        = out_q;

endmodule

[hdl/murmur3_32_hasher_top.sv]
`timescale 1ns / 1ps
// Sequence: each word is accepted, then scrambled by two multiplies; a word that does not
//   end the key is then mixed in; the final word takes a mix and length step (full) or a
//   tail step (partial), two finalize multiplies, and an emit once the output is free.
// Input: a new word is taken only after the previous one has been mixed in or finalized.
// Reset: arst_n clears the controller, the seed register and the output valid.
module murmur3_32_hasher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// seed register write
	input  logic                          seed_we,
	input  logic [mm3_pkg::WordW-1:0]     seed_wdata,
	// key word requests
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mm3_pkg::TdataW-1:0]    s_axis_tdata,  // [31:0] key_word, [34:32] byte_count
	input  logic                          s_axis_tlast,  // last word of the key
	// hash results
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mm3_pkg::WordW-1:0]     m_axis_tdata   // [31:0] hash
);
	import mm3_pkg::*;

	cmd_t    cmd;
	status_t st;

	// The controller steps through scramble, mix and finalize; the datapath
	// holds the running hash, the byte length and the output register, so a
	// finished hash can wait there while the next key word is taken in.
	mm3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mm3_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.key_word   (s_axis_tdata[WordW-1:0]),
		.byte_count (s_axis_tdata[WordW+CountW-1:WordW]),
		.last       (s_axis_tlast),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.hash       (m_axis_tdata)
	);

endmodule

[hdl/mm3_checker.sv]
`timescale 1ns / 1ps

module mm3_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [mm3_pkg::WordW-1:0]  m_axis_tdata
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// a stalled hash holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("hash changed or dropped while stalled");

	// a taken word blocks the input while it is scrambled
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("input ready right after a word was taken");

	// finalize lies between the last word and the rise of its hash
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(in_acc, 1) && !$past(in_acc, 2)
			&& !$past(in_acc, 3))
		else $error("hash appeared too soon after an input word");

	// no result once a clock edge has seen reset
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind murmur3_32_hasher_top mm3_checker u_mm3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
